// ===== src/rrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rrsp_pkg
// Types, codes and helpers shared by the routing record stream parser.
// ----------------------------------------------------------------------------
package rrsp_pkg;

  // Parser phase, one-hot
  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_INFO   = 6'b000010,
    PH_DELETE = 6'b000100,
    PH_FIXED  = 6'b001000,
    PH_PATH   = 6'b010000,
    PH_SKIP   = 6'b100000
  } phase_t;

  // Record kinds
  localparam logic [2:0] KIND_FLUSH   = 3'd0;
  localparam logic [2:0] KIND_REQUEST = 3'd1;
  localparam logic [2:0] KIND_INFO    = 3'd2;
  localparam logic [2:0] KIND_DELETE  = 3'd3;
  localparam logic [2:0] KIND_UPDATE  = 3'd4;

  // Field tags
  localparam logic [3:0] TAG_NONE       = 4'd0;
  localparam logic [3:0] TAG_INFO_FIRST = 4'd1;
  localparam logic [3:0] TAG_INFO_LAST  = 4'd8;
  localparam logic [3:0] TAG_NODE       = 4'd9;
  localparam logic [3:0] TAG_CAP        = 4'd10;
  localparam logic [3:0] TAG_HOPS       = 4'd11;
  localparam logic [3:0] TAG_COST       = 4'd12;
  localparam logic [3:0] TAG_PATH       = 4'd13;

  // Stream status
  localparam logic [2:0] ST_RUN       = 3'd0;
  localparam logic [2:0] ST_OK        = 3'd1;
  localparam logic [2:0] ST_INFO_CUT  = 3'd2;
  localparam logic [2:0] ST_DEL_CUT   = 3'd3;
  localparam logic [2:0] ST_FIXED_CUT = 3'd4;
  localparam logic [2:0] ST_PATH_CUT  = 3'd5;
  localparam logic [2:0] ST_BAD_OP    = 3'd6;

  // Configuration register indexes
  localparam logic [2:0] CFG_FLUSH   = 3'd0;
  localparam logic [2:0] CFG_REQUEST = 3'd1;
  localparam logic [2:0] CFG_INFO    = 3'd2;
  localparam logic [2:0] CFG_DELETE  = 3'd3;
  localparam logic [2:0] CFG_UPDATE  = 3'd4;

  typedef struct packed {
    logic [7:0] code_flush;
    logic [7:0] code_request;
    logic [7:0] code_info;
    logic [7:0] code_delete;
    logic [7:0] code_update;
  } codes_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [3:0]  field_tag;
    logic [31:0] field_value;
    logic        record_done;
    logic [2:0]  stream_status;
    logic        field_valid;
  } res_t;

  // Field length in bytes, modulo 4 (a 4-byte cost wraps to 0)
  function automatic logic [1:0] field_len(input logic [3:0] tag);
    logic [1:0] len;
    case (tag) inside
      [TAG_INFO_FIRST:TAG_INFO_LAST], TAG_HOPS: len = 2'd2;
      TAG_NODE, TAG_PATH:                       len = 2'd3;
      TAG_CAP:                                  len = 2'd1;
      default:                                  len = 2'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== src/rrsp_in_if.sv =====
// ----------------------------------------------------------------------------
// rrsp_in_if
// Byte stream channel: valid/ready handshake with a byte and end flag.
// ----------------------------------------------------------------------------
interface rrsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// ===== src/rrsp_out_if.sv =====
// ----------------------------------------------------------------------------
// rrsp_out_if
// Result channel: valid/ready handshake with one tagged field per word.
// ----------------------------------------------------------------------------
interface rrsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  record_kind;
  logic [3:0]  field_tag;
  logic [31:0] field_value;
  logic        record_done;
  logic [2:0]  stream_status;
  logic        field_valid;

  modport source (output valid, output record_kind, output field_tag, output field_value,
                  output record_done, output stream_status, output field_valid,
                  input ready);
  modport sink   (input valid, input record_kind, input field_tag, input field_value,
                  input record_done, input stream_status, input field_valid,
                  output ready);
endinterface

// ===== src/routing_record_stream_parser.sv =====
// ----------------------------------------------------------------------------
// routing_record_stream_parser
// Byte-wise parser of routing records into tagged fields.
// ----------------------------------------------------------------------------
// Bytes arrive on in_ch, one per word, end_of_stream set on the last byte.
// Each completed field, completed record or stream status leaves on out_ch
// as one word; bytes inside a field give no word. Opcode values come from
// five registers written through cfg_we / cfg_index / cfg_data; the user
// must write them only while idle, which the block does not enforce. Bytes
// pass from the input register through decode into the result register, one
// byte per cycle unless out_ch stalls, set by the single decode stage between
// the two registers. When out_ch stalls, the result register holds; the input
// register still takes a byte, and in_ch.ready drops only when both are full.
// Synchronous reset empties both registers, puts the parser idle awaiting
// an opcode and restores the default opcodes 1 to 5.
// ----------------------------------------------------------------------------
module routing_record_stream_parser (
  input  logic       clk,
  input  logic       rst_n,
  rrsp_in_if.sink    in_ch,
  rrsp_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import rrsp_pkg::*;

  codes_t     codes_r;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eos;
  logic       out_free;
  logic       go;
  logic       emit;
  res_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.code_flush   <= 8'd1;
      codes_r.code_request <= 8'd2;
      codes_r.code_info    <= 8'd3;
      codes_r.code_delete  <= 8'd4;
      codes_r.code_update  <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FLUSH:   codes_r.code_flush   <= cfg_data;
        CFG_REQUEST: codes_r.code_request <= cfg_data;
        CFG_INFO:    codes_r.code_info    <= cfg_data;
        CFG_DELETE:  codes_r.code_delete  <= cfg_data;
        CFG_UPDATE:  codes_r.code_update  <= cfg_data;
        default:     ;
      endcase
    end
  end

  // advance only when the result register has room, whether or not a result is made
  assign go = in_valid && out_free;

  rrsp_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .advance   (go),
    .valid     (in_valid),
    .data_byte (in_byte),
    .eos       (in_eos)
  );

  rrsp_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .codes     (codes_r),
    .go        (go),
    .data_byte (in_byte),
    .eos       (in_eos),
    .res       (res),
    .emit      (emit)
  );

  rrsp_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (go && emit),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );
endmodule

// ===== src/rrsp_in_reg.sv =====
// ----------------------------------------------------------------------------
// rrsp_in_reg
// Input register: holds one stream word until the parser consumes it.
// ----------------------------------------------------------------------------
module rrsp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  rrsp_in_if.sink    in_ch,
  input  logic       advance,
  output logic       valid,
  output logic [7:0] data_byte,
  output logic       eos
);
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       eos_r;
  logic       take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_ch.data_byte;
      eos_r  <= in_ch.end_of_stream;
    end
  end

  assign valid     = valid_r;
  assign data_byte = byte_r;
  assign eos       = eos_r;
endmodule

// ===== src/rrsp_step.sv =====
// ----------------------------------------------------------------------------
// rrsp_step
// Parser state and per-byte decode: opcode match, field assembly, status.
// ----------------------------------------------------------------------------
module rrsp_step (
  input  logic             clk,
  input  logic             rst_n,
  input  rrsp_pkg::codes_t codes,
  input  logic             go,
  input  logic [7:0]       data_byte,
  input  logic             eos,
  output rrsp_pkg::res_t   res,
  output logic             emit
);
  import rrsp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [1:0]  bif_r, bif_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [15:0] hops_r, hops_nxt;

  logic [1:0]  bif_inc;
  logic [31:0] word;
  logic [15:0] hops_dec;
  logic        bad, active, fvalid, done;
  logic [3:0]  tag;
  logic [31:0] val;
  logic [2:0]  status;

  assign bif_inc  = bif_r + 2'd1;
  assign word     = {acc_r, data_byte};
  assign hops_dec = hops_r - 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    idx_nxt   = idx_r;
    bif_nxt   = bif_r;
    acc_nxt   = acc_r;
    hops_nxt  = hops_r;
    bad       = 1'b0;
    fvalid    = 1'b0;
    done      = 1'b0;
    tag       = TAG_NONE;
    val       = 32'd0;
    status    = ST_RUN;

    case (phase_r)
      PH_SKIP: begin
        if (eos) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_IDLE: begin
        acc_nxt = 24'd0;
        bif_nxt = 2'd0;
        // first match wins when codes collide
        if (data_byte == codes.code_flush) begin
          kind_nxt = KIND_FLUSH;
          done     = 1'b1;
        end else if (data_byte == codes.code_request) begin
          kind_nxt = KIND_REQUEST;
          done     = 1'b1;
        end else if (data_byte == codes.code_info) begin
          kind_nxt  = KIND_INFO;
          idx_nxt   = TAG_INFO_FIRST;
          phase_nxt = PH_INFO;
        end else if (data_byte == codes.code_delete) begin
          kind_nxt  = KIND_DELETE;
          idx_nxt   = TAG_NODE;
          phase_nxt = PH_DELETE;
        end else if (data_byte == codes.code_update) begin
          kind_nxt  = KIND_UPDATE;
          idx_nxt   = TAG_NODE;
          phase_nxt = PH_FIXED;
        end else begin
          bad       = 1'b1;
          kind_nxt  = KIND_FLUSH;
          phase_nxt = eos ? PH_IDLE : PH_SKIP;
        end
      end
      default: begin
        acc_nxt = word[23:0];
        bif_nxt = bif_inc;
        if (bif_inc == field_len(idx_r)) begin
          fvalid  = 1'b1;
          tag     = idx_r;
          val     = word;
          acc_nxt = 24'd0;
          bif_nxt = 2'd0;
          case (phase_r)
            PH_INFO: begin
              if (idx_r < TAG_INFO_LAST) begin
                idx_nxt = idx_r + 4'd1;
              end else begin
                done = 1'b1;
              end
            end
            PH_DELETE: begin
              done = 1'b1;
            end
            PH_FIXED: begin
              if (idx_r == TAG_HOPS) begin
                hops_nxt = word[15:0];
              end
              if (idx_r < TAG_COST) begin
                idx_nxt = idx_r + 4'd1;
              end else if (hops_r == 16'd0) begin
                done = 1'b1;
              end else begin
                phase_nxt = PH_PATH;
                idx_nxt   = TAG_PATH;
              end
            end
            default: begin
              hops_nxt = hops_dec;
              if (hops_dec == 16'd0) begin
                done = 1'b1;
              end
            end
          endcase
        end
      end
    endcase

    active = (phase_r != PH_SKIP) && !bad;

    if (active && done) begin
      phase_nxt = PH_IDLE;
      idx_nxt   = 4'd0;
      bif_nxt   = 2'd0;
      acc_nxt   = 24'd0;
    end

    if (active && eos) begin
      if (done) begin
        status = ST_OK;
      end else begin
        case (phase_nxt)
          PH_INFO:   status = ST_INFO_CUT;
          PH_DELETE: status = ST_DEL_CUT;
          PH_FIXED:  status = ST_FIXED_CUT;
          default:   status = ST_PATH_CUT;
        endcase
      end
      phase_nxt = PH_IDLE;
      idx_nxt   = 4'd0;
      bif_nxt   = 2'd0;
      acc_nxt   = 24'd0;
      hops_nxt  = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      kind_r  <= KIND_FLUSH;
      idx_r   <= 4'd0;
      bif_r   <= 2'd0;
      acc_r   <= 24'd0;
      hops_r  <= 16'd0;
    end else if (go) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      idx_r   <= idx_nxt;
      bif_r   <= bif_nxt;
      acc_r   <= acc_nxt;
      hops_r  <= hops_nxt;
    end
  end

  assign emit = bad || (active && (fvalid || done || (status != ST_RUN)));

  always_comb begin
    if (bad) begin
      res.record_kind   = KIND_FLUSH;
      res.field_tag     = TAG_NONE;
      res.field_value   = 32'd0;
      res.record_done   = 1'b0;
      res.stream_status = ST_BAD_OP;
      res.field_valid   = 1'b0;
    end else begin
      res.record_kind   = kind_nxt;
      res.field_tag     = tag;
      res.field_value   = val;
      res.record_done   = done;
      res.stream_status = status;
      res.field_valid   = fvalid;
    end
  end
endmodule

// ===== src/rrsp_out_reg.sv =====
// ----------------------------------------------------------------------------
// rrsp_out_reg
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module rrsp_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  rrsp_pkg::res_t res,
  output logic           free,
  rrsp_out_if.source     out_ch
);
  import rrsp_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.record_kind   = res_r.record_kind;
  assign out_ch.field_tag     = res_r.field_tag;
  assign out_ch.field_value   = res_r.field_value;
  assign out_ch.record_done   = res_r.record_done;
  assign out_ch.stream_status = res_r.stream_status;
  assign out_ch.field_valid   = res_r.field_valid;
endmodule
